>>> src/lr_pkg.sv
// ---------------------------------------------------------------------------
// lr_pkg
// Shared types and constants for the line rasterizer.
// ---------------------------------------------------------------------------
package lr_pkg;

  localparam int CoordW = 6;
  localparam int ColorW = 32;
  // error accumulator: err < threshold <= 64, err + incr <= 127
  localparam int ErrW   = CoordW + 1;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [ErrW-1:0]   err_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_DRAW  = 3'b100
  } state_t;

  // result of one accumulator step
  typedef struct packed {
    logic step;
    err_t err;
  } step_res_t;

endpackage

>>> src/lr_step_unit.sv
// ---------------------------------------------------------------------------
// lr_step_unit
// Error accumulator step: add the minor increment, compare against the
// threshold and fold back once when it is reached.
// ---------------------------------------------------------------------------
module lr_step_unit (
  input  lr_pkg::err_t      err,
  input  lr_pkg::err_t      incr,
  input  lr_pkg::err_t      thr,
  output lr_pkg::step_res_t res
);
  import lr_pkg::*;

  err_t sum;

  always_comb begin
    sum      = err + incr;
    res.step = (sum >= thr);
    res.err  = res.step ? err_t'(sum - thr) : sum;
  end

endmodule

>>> src/line_rasterizer.sv
// ---------------------------------------------------------------------------
// line_rasterizer
// Draws one line per command, one pixel beat per cycle, using an
// incremental error accumulator stepped by a single step unit.
//
//   channel  ports                          handshake
//   -------  -----------------------------  ---------------------------
//   command  in_start_x/y, in_end_x/y,      taken when start & !busy
//            in_color
//   pixel    out_pixel_x/y, out_pixel_color out_valid, one cycle, no stall
//            out_last
//
// A command runs through a capture step when start is taken, a setup step,
// then one pixel per cycle stepped by the step unit until the last pixel,
// after which start can be taken again. rst_n is synchronous and clears
// only the sequencer and the strobe. The receiver cannot stall, so pixels
// leave at a fixed rate once drawing has begun.
// ---------------------------------------------------------------------------
module line_rasterizer #(
  parameter int TILE_SIZE = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  lr_pkg::coord_t       in_start_x,
  input  lr_pkg::coord_t       in_start_y,
  input  lr_pkg::coord_t       in_end_x,
  input  lr_pkg::coord_t       in_end_y,
  input  logic [31:0]          in_color,
  output logic                 out_valid,
  output lr_pkg::coord_t       out_pixel_x,
  output lr_pkg::coord_t       out_pixel_y,
  output logic [31:0]          out_pixel_color,
  output logic                 out_last
);
  import lr_pkg::*;

  localparam coord_t CoordMax = coord_t'(TILE_SIZE - 1);

  state_t    state_r, state_nxt;
  coord_t    sx_r, sy_r, ex_r, ey_r;
  logic [ColorW-1:0] color_r;

  logic      steep_r, up_r, down_r;
  coord_t    maj_r, maj_end_r, mnr_r;
  err_t      err_r, incr_r, thr_r;

  logic      out_valid_r, out_last_r;
  coord_t    out_x_r, out_y_r;

  // setup logic
  coord_t    dx, dy, maj0, maj1, min0, min1, major_span, minor_span;
  logic      steep;
  err_t      incr_s;
  step_res_t sres;

  function automatic coord_t clamp(input coord_t v);
    clamp = (v > CoordMax) ? CoordMax : v;
  endfunction

  always_comb begin
    dx    = (sx_r > ex_r) ? coord_t'(sx_r - ex_r) : coord_t'(ex_r - sx_r);
    dy    = (sy_r > ey_r) ? coord_t'(sy_r - ey_r) : coord_t'(ey_r - sy_r);
    steep = (dy > dx);
    if (steep) begin
      maj0 = sy_r; maj1 = ey_r; min0 = sx_r; min1 = ex_r;
      major_span = dy; minor_span = dx;
    end else begin
      maj0 = sx_r; maj1 = ex_r; min0 = sy_r; min1 = ey_r;
      major_span = dx; minor_span = dy;
    end
    // endpoints swap so the major coordinate rises
    if (maj0 > maj1) begin
      {maj0, maj1} = {maj1, maj0};
      {min0, min1} = {min1, min0};
    end
    incr_s = {1'b0, minor_span} + err_t'(1);
  end

  lr_step_unit u_step (
    .err  (err_r),
    .incr (incr_r),
    .thr  (thr_r),
    .res  (sres)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_DRAW;
      ST_DRAW:  if (maj_r == maj_end_r) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_DRAW);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          sx_r    <= clamp(in_start_x);
          sy_r    <= clamp(in_start_y);
          ex_r    <= clamp(in_end_x);
          ey_r    <= clamp(in_end_y);
          color_r <= in_color;
        end
      end
      ST_SETUP: begin
        steep_r   <= steep;
        maj_r     <= maj0;
        maj_end_r <= maj1;
        mnr_r     <= min0;
        up_r      <= (min1 > min0);
        down_r    <= (min1 < min0);
        incr_r    <= incr_s;
        thr_r     <= {1'b0, major_span} + err_t'(1);
        err_r     <= incr_s >> 1;
      end
      ST_DRAW: begin
        out_x_r    <= steep_r ? mnr_r : maj_r;
        out_y_r    <= steep_r ? maj_r : mnr_r;
        out_last_r <= (maj_r == maj_end_r);
        maj_r      <= maj_r + coord_t'(1);
        err_r      <= sres.err;
        if (sres.step && up_r)   mnr_r <= mnr_r + coord_t'(1);
        if (sres.step && down_r) mnr_r <= mnr_r - coord_t'(1);
      end
      default: ;
    endcase
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_color = color_r;
  assign out_last        = out_last_r;

endmodule
